// ===== src/trd_pkg.sv =====
// Package for the run-length encoded true-color image decoder.
// It holds the parser phase type, header byte positions, result kinds and the result record.
// It has no dependencies; all decoder modules import it.
`default_nettype none

package trd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PACKET = 2'd1,
    PH_COLOUR = 2'd2
  } phase_e;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [4:0] HPOS_ID_LEN     = 5'd0;
  localparam logic [4:0] HPOS_CMAP_TYPE  = 5'd1;
  localparam logic [4:0] HPOS_IMAGE_TYPE = 5'd2;
  localparam logic [4:0] HPOS_X_ORG_LO   = 5'd8;
  localparam logic [4:0] HPOS_Y_ORG_HI   = 5'd11;
  localparam logic [4:0] HPOS_WIDTH_LO   = 5'd12;
  localparam logic [4:0] HPOS_WIDTH_HI   = 5'd13;
  localparam logic [4:0] HPOS_HEIGHT_LO  = 5'd14;
  localparam logic [4:0] HPOS_HEIGHT_HI  = 5'd15;
  localparam logic [4:0] HPOS_DEPTH      = 5'd16;
  localparam logic [4:0] HPOS_DESCRIPTOR = 5'd17;

  localparam logic [7:0] IMAGE_TYPE_RLE_RGB = 8'd10;

  localparam logic [1:0] CBI_BLUE  = 2'd0;
  localparam logic [1:0] CBI_GREEN = 2'd1;
  localparam logic [1:0] CBI_RED   = 2'd2;

  localparam int unsigned TDATA_W = 80;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  pixel_depth;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  repeat_count;
    logic        image_done;
  } result_t;

endpackage

`default_nettype wire

// ===== src/trd_front.sv =====
// Front end of the decoder: accepts stream bytes, parses the header and the packets.
// It keeps all parser state and pushes one result record per result into the queue.
// Depends on trd_pkg.
`default_nettype none

module trd_front
  import trd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_start_i,
  input  logic       q_ready_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [4:0]  hpos_q, hpos_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [7:0]  depth_q, depth_d;
  logic        bad_q, bad_d;
  logic [31:0] pixels_q, pixels_d;
  logic        is_run_q, is_run_d;
  logic [7:0]  pkt_q, pkt_d;
  logic [1:0]  cbi_q, cbi_d;
  logic [7:0]  blue_q, blue_d;
  logic [7:0]  green_q, green_d;

  logic        accept;
  phase_e      eff_phase;
  logic [4:0]  eff_hpos;
  logic        eff_bad;
  logic        hdr_last;
  logic        hdr_bad_fin;
  logic        img_empty;
  logic [31:0] area;
  logic [7:0]  rep;
  logic [31:0] pix_next;
  logic [7:0]  pkt_next;
  logic        pix_done;

  assign accept     = in_valid_i & q_ready_i;
  assign in_ready_o = q_ready_i;

  assign eff_phase = frame_start_i ? PH_HEADER : phase_q;
  assign eff_hpos  = frame_start_i ? HPOS_ID_LEN : hpos_q;
  assign eff_bad   = frame_start_i ? 1'b0 : bad_q;

  assign hdr_last    = (eff_hpos == HPOS_DESCRIPTOR);
  assign hdr_bad_fin = eff_bad | (data_byte_i != 8'd0);
  assign img_empty   = (width_q == 16'd0) | (height_q == 16'd0);
  assign area        = {16'd0, width_q} * {16'd0, height_q};

  always_comb begin
    if (is_run_q) begin
      rep = (pixels_q < {24'd0, pkt_q}) ? pixels_q[7:0] : pkt_q;
    end else begin
      rep = (pixels_q != 32'd0) ? 8'd1 : 8'd0;
    end
  end

  assign pix_next = pixels_q - {24'd0, rep};
  assign pkt_next = (is_run_q || pkt_q == 8'd0) ? 8'd0 : pkt_q - 8'd1;
  assign pix_done = (pix_next == 32'd0);

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (eff_phase)
        PH_PACKET: phase_d = PH_COLOUR;
        PH_COLOUR: begin
          if (cbi_q != CBI_BLUE && cbi_q != CBI_GREEN) begin
            if (pix_done) begin
              phase_d = PH_HEADER;
            end else if (pkt_next == 8'd0) begin
              phase_d = PH_PACKET;
            end
          end
        end
        default: begin
          if (hdr_last && !hdr_bad_fin && !img_empty) begin
            phase_d = PH_PACKET;
          end else begin
            phase_d = PH_HEADER;
          end
        end
      endcase
    end
  end

  always_comb begin
    hpos_d   = hpos_q;
    width_d  = width_q;
    height_d = height_q;
    depth_d  = depth_q;
    bad_d    = bad_q;
    pixels_d = pixels_q;
    is_run_d = is_run_q;
    pkt_d    = pkt_q;
    cbi_d    = cbi_q;
    blue_d   = blue_q;
    green_d  = green_q;

    res_valid_o        = 1'b0;
    res_o.kind         = KIND_HEADER;
    res_o.image_width  = width_q;
    res_o.image_height = height_q;
    res_o.pixel_depth  = depth_q;
    res_o.red          = 8'd0;
    res_o.green        = 8'd0;
    res_o.blue         = 8'd0;
    res_o.repeat_count = 8'd0;
    res_o.image_done   = 1'b0;

    if (accept) begin
      unique case (eff_phase)
        PH_PACKET: begin
          is_run_d = data_byte_i[7];
          pkt_d    = {1'b0, data_byte_i[6:0]} + 8'd1;
          cbi_d    = CBI_BLUE;
        end
        PH_COLOUR: begin
          case (cbi_q)
            CBI_BLUE: begin
              blue_d = data_byte_i;
              cbi_d  = CBI_GREEN;
            end
            CBI_GREEN: begin
              green_d = data_byte_i;
              cbi_d   = CBI_RED;
            end
            default: begin
              pixels_d           = pix_next;
              pkt_d              = pkt_next;
              cbi_d              = CBI_BLUE;
              res_valid_o        = 1'b1;
              res_o.kind         = KIND_PIXEL;
              res_o.red          = data_byte_i;
              res_o.green        = green_q;
              res_o.blue         = blue_q;
              res_o.repeat_count = rep;
              res_o.image_done   = pix_done;
              if (pix_done) begin
                hpos_d = HPOS_ID_LEN;
                bad_d  = 1'b0;
              end
            end
          endcase
        end
        default: begin
          hpos_d = eff_hpos + 5'd1;
          bad_d  = eff_bad;
          unique case (eff_hpos) inside
            HPOS_ID_LEN, HPOS_CMAP_TYPE, [HPOS_X_ORG_LO:HPOS_Y_ORG_HI], HPOS_DESCRIPTOR: begin
              if (data_byte_i != 8'd0) begin
                bad_d = 1'b1;
              end
            end
            HPOS_IMAGE_TYPE: begin
              if (data_byte_i != IMAGE_TYPE_RLE_RGB) begin
                bad_d = 1'b1;
              end
            end
            HPOS_WIDTH_LO:  width_d  = {8'd0, data_byte_i};
            HPOS_WIDTH_HI:  width_d  = {data_byte_i, width_q[7:0]};
            HPOS_HEIGHT_LO: height_d = {8'd0, data_byte_i};
            HPOS_HEIGHT_HI: height_d = {data_byte_i, height_q[7:0]};
            HPOS_DEPTH:     depth_d  = data_byte_i;
            default: ;
          endcase
          if (hdr_last) begin
            hpos_d      = HPOS_ID_LEN;
            bad_d       = 1'b0;
            res_valid_o = 1'b1;
            if (hdr_bad_fin) begin
              res_o.kind = KIND_ERROR;
            end else begin
              res_o.image_done = img_empty;
              pixels_d         = area;
              pkt_d            = 8'd0;
              cbi_d            = CBI_BLUE;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      hpos_q   <= HPOS_ID_LEN;
      width_q  <= 16'd0;
      height_q <= 16'd0;
      depth_q  <= 8'd0;
      bad_q    <= 1'b0;
      pixels_q <= 32'd0;
      is_run_q <= 1'b0;
      pkt_q    <= 8'd0;
      cbi_q    <= CBI_BLUE;
      blue_q   <= 8'd0;
      green_q  <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      hpos_q   <= hpos_d;
      width_q  <= width_d;
      height_q <= height_d;
      depth_q  <= depth_d;
      bad_q    <= bad_d;
      pixels_q <= pixels_d;
      is_run_q <= is_run_d;
      pkt_q    <= pkt_d;
      cbi_q    <= cbi_d;
      blue_q   <= blue_d;
      green_q  <= green_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/trd_queue.sv =====
// Two-entry result queue between the parser front end and the output back end.
// Either side can stall without stopping the other for up to two results.
// Depends on trd_pkg.
`default_nettype none

module trd_queue
  import trd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    ready_o,
  input  logic    pop_i,
  output logic    valid_o,
  output result_t head_o
);

  result_t    entries_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/trd_back.sv =====
// Back end of the decoder: takes result records from the queue and formats them.
// It packs the output word and holds it in the output register until transfer.
// Depends on trd_pkg.
`default_nettype none

module trd_back
  import trd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  result_t            q_head_i,
  output logic               q_pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]         m_axis_tuser,
  output logic               m_axis_tlast
);

  logic               valid_q;
  logic [TDATA_W-1:0] tdata_q;
  logic [1:0]         tuser_q;
  logic               tlast_q;
  logic [TDATA_W-1:0] packed_data;

  assign packed_data = {q_head_i.repeat_count,
                        q_head_i.red, q_head_i.green, q_head_i.blue, 8'd0,
                        q_head_i.pixel_depth,
                        q_head_i.image_height,
                        q_head_i.image_width};

  assign q_pop_o = q_valid_i & (~valid_q | m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      tdata_q <= packed_data;
      tuser_q <= q_head_i.kind;
      tlast_q <= q_head_i.image_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;
  assign m_axis_tlast  = tlast_q;

endmodule

`default_nettype wire

// ===== src/tga_rle_truecolor_decoder.sv =====
// Top level of the run-length encoded true-color image decoder.
// Instantiates the parser front end, the result queue and the output back end.
// Depends on trd_pkg, trd_front, trd_queue and trd_back.
//
//  Port group   Dir  Payload
//  s_axis       in   tdata: data_byte; tuser: frame_start
//  m_axis       out  tdata: width, height, depth, rgba, repeat; tuser: kind; tlast: done
//
// One byte is accepted per cycle while the queue has room; the parser updates its state in that cycle.
// A result is registered in the queue and then in the output register before it reaches m_axis.
// Reset clears the parser to the header phase and empties the queue.
// A stalled output holds results in the two-entry queue and then stalls the input.
`default_nettype none

module tga_rle_truecolor_decoder
  import trd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
  input  logic               s_axis_tuser,   // [0] frame_start
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // [15:0] image_width, [31:16] image_height,
                                             // [39:32] pixel_depth, [71:40] pixel_rgba,
                                             // [79:72] repeat_count
  output logic [1:0]         m_axis_tuser,   // [1:0] kind
  output logic               m_axis_tlast    // image_done
);

  logic    q_ready;
  logic    push;
  result_t push_data;
  logic    q_valid;
  result_t q_head;
  logic    q_pop;

  trd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .data_byte_i  (s_axis_tdata),
    .frame_start_i(s_axis_tuser),
    .q_ready_i    (q_ready),
    .res_valid_o  (push),
    .res_o        (push_data)
  );

  trd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  trd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  a_pixel_nonzero_repeat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_PIXEL |-> m_axis_tdata[79:72] != 8'd0)
    else $error("pixel result with zero repeat count");

  a_error_not_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> !m_axis_tlast)
    else $error("header error marked as image end");

  a_header_no_pixel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_PIXEL |-> m_axis_tdata[79:40] == 40'd0)
    else $error("header result carries pixel data");

  a_queue_holds_when_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_ready |-> q_valid && m_axis_tvalid)
    else $error("input stalled while the output side is not full");

endmodule

`default_nettype wire
